/* sv/mask_lighten_pixel_defines.svh */
// Assertion macros shared by the pixel-lightening RTL.
// No dependencies; included by the files that carry checks.
`ifndef MASK_LIGHTEN_PIXEL_DEFINES_SVH
`define MASK_LIGHTEN_PIXEL_DEFINES_SVH

// Same-cycle implication under synchronous reset.
`define MLP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under synchronous reset.
`define MLP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/mlp_pkg.sv */
// Types and constants for the pixel-lightening block.
// No dependencies; imported by every module of the block.
package mlp_pkg;

  localparam int NUM_LANES = 6;

  localparam logic [1:0] FMT_555 = 2'd0;
  localparam logic [1:0] FMT_565 = 2'd1;
  localparam logic [1:0] FMT_24  = 2'd2;
  localparam logic [1:0] FMT_32  = 2'd3;

  localparam logic [1:0] FMT_RESET = FMT_32;

  localparam logic [8:0] ALP_BIAS       = 9'd64;
  localparam logic [7:0] CHAN_FORCE_LIM = 8'd250;
  localparam logic [7:0] MAX_5          = 8'h1F;
  localparam logic [7:0] MAX_6          = 8'h3F;
  localparam logic [7:0] MAX_8          = 8'hFF;

  localparam logic [15:0] WHITE_555 = 16'h7FFF;
  localparam logic [23:0] WHITE_888 = 24'hFFFFFF;

  localparam logic REG_FORMAT = 1'b0;

  typedef struct packed {
    logic [7:0] chan;
    logic [8:0] alp;
    logic [7:0] maxv;
    logic       force_full;
  } lane_in_t;

  typedef struct packed {
    logic [1:0]  fmt;
    logic        mask_zero;
    logic [31:0] word;
  } ctl_t;

endpackage

/* sv/mlp_lane.sv */
// One channel lane: multiply by (mask+64), shift by 6, saturate to maxv; force_full with a channel above 250 gives 255.
// Depends on mlp_pkg.
module mlp_lane import mlp_pkg::*; (
  input  logic       clk,
  input  lane_in_t   lane_in,
  output logic [7:0] lane_out
);

  logic [16:0] prod;
  logic [10:0] scaled;
  logic [7:0]  lane_next;

  assign prod   = {9'd0, lane_in.chan} * {8'd0, lane_in.alp};
  assign scaled = prod[16:6];

  always_comb begin
    if (lane_in.force_full && (lane_in.chan > CHAN_FORCE_LIM)) begin
      lane_next = MAX_8;
    end else if (scaled > {3'd0, lane_in.maxv}) begin
      lane_next = lane_in.maxv;
    end else begin
      lane_next = scaled[7:0];
    end
  end

  always_ff @(posedge clk) begin
    lane_out <= lane_next;
  end

endmodule

/* sv/mlp_merge.sv */
// Merge stage: packs lane results per format and applies the skip rules (none in 565 mode).
// Depends on mlp_pkg.
module mlp_merge import mlp_pkg::*; (
  input  logic                       clk,
  input  ctl_t                       ctl,
  input  logic [NUM_LANES-1:0][7:0]  lanes,
  output logic [31:0]                lit_word
);

  logic [31:0] word_next;
  logic        skip;

  always_comb begin
    skip      = 1'b0;
    word_next = ctl.word;
    unique case (ctl.fmt)
      FMT_555: begin
        skip = ctl.mask_zero || (ctl.word[15:0] == 16'd0) ||
               (ctl.word[15:0] == WHITE_555);
        if (skip) begin
          word_next = {16'd0, ctl.word[15:0]};
        end else begin
          word_next = {17'd0, lanes[2][7:3], lanes[1][7:3], lanes[0][7:3]};
        end
      end
      FMT_565: begin
        word_next = {lanes[5][4:0], lanes[4][5:0], lanes[3][4:0],
                     lanes[2][4:0], lanes[1][5:0], lanes[0][4:0]};
      end
      FMT_24: begin
        skip = ctl.mask_zero || (ctl.word[23:0] == 24'd0) ||
               (ctl.word[23:0] == WHITE_888);
        if (!skip) begin
          word_next = {ctl.word[31:24], lanes[2], lanes[1], lanes[0]};
        end
      end
      default: begin
        skip = ctl.mask_zero || (ctl.word == 32'd0) ||
               (ctl.word == {8'd0, WHITE_888});
        if (!skip) begin
          word_next = {8'd0, lanes[2], lanes[1], lanes[0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    lit_word <= word_next;
  end

endmodule

/* sv/mask_lighten_pixel.sv */
// Top level of the pixel-lightening block: config register, lane fan-out.
// Depends on mlp_pkg, mlp_lane, mlp_merge and the assertion macro header.
`include "mask_lighten_pixel_defines.svh"

// Lightens one pixel word per transaction by an 8-bit light mask (in 565
// mode, mask_second for the high pixel). A transaction is taken at any clock
// edge with start high; busy is always low, so a new word may follow every
// cycle. The result for a word shows on lit_word with done high for exactly
// one cycle, after one register stage in the six channel lanes and one in
// the merge stage. The receiver cannot stall: sample lit_word whenever done
// is high. Results come out in the order the words went in. pixel_format is
// set through the APB port at addresses 0 to 3 (paddr[2] low) and may only
// change while no transaction is in flight; a transaction uses the format in
// force when it was taken.
module mask_lighten_pixel import mlp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  mask_first,
  input  logic [7:0]  mask_second,
  input  logic [31:0] pixel_word,
  // result strobe
  output logic        done,
  output logic [31:0] lit_word,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0] pixel_format;
  logic       cfg_wr;

  lane_in_t                   lane_in [NUM_LANES];
  logic [NUM_LANES-1:0][7:0]  lane_res;

  logic [8:0] alp_first;
  logic [8:0] alp_second;
  logic       accept;
  logic       s1_valid;
  ctl_t       s1_ctl;

  // No backpressure anywhere: take a word every cycle.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // APB register file: a single format register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_FORMAT);
  assign prdata = (paddr[2] == REG_FORMAT) ? {30'd0, pixel_format} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= FMT_RESET;
    end else if (cfg_wr) begin
      pixel_format <= pwdata[1:0];
    end
  end

  assign alp_first  = {1'b0, mask_first} + ALP_BIAS;
  assign alp_second = {1'b0, mask_second} + ALP_BIAS;

  // Fan the word out to the lanes. Lanes 0..2 carry blue, green, red of the
  // pixel (low pixel in 565 mode); lanes 3..5 carry the high 565 pixel.
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      lane_in[i] = '{chan: 8'd0, alp: alp_first, maxv: MAX_8, force_full: 1'b1};
    end
    unique case (pixel_format)
      FMT_555: begin
        // widen 5-bit channels by replicating the top bits
        lane_in[0].chan = {pixel_word[4:0],   pixel_word[4:2]};
        lane_in[1].chan = {pixel_word[9:5],   pixel_word[9:7]};
        lane_in[2].chan = {pixel_word[14:10], pixel_word[14:12]};
      end
      FMT_565: begin
        lane_in[0] = '{chan: {3'd0, pixel_word[4:0]},   alp: alp_first,
                       maxv: MAX_5, force_full: 1'b0};
        lane_in[1] = '{chan: {2'd0, pixel_word[10:5]},  alp: alp_first,
                       maxv: MAX_6, force_full: 1'b0};
        lane_in[2] = '{chan: {3'd0, pixel_word[15:11]}, alp: alp_first,
                       maxv: MAX_5, force_full: 1'b0};
        lane_in[3] = '{chan: {3'd0, pixel_word[20:16]}, alp: alp_second,
                       maxv: MAX_5, force_full: 1'b0};
        lane_in[4] = '{chan: {2'd0, pixel_word[26:21]}, alp: alp_second,
                       maxv: MAX_6, force_full: 1'b0};
        lane_in[5] = '{chan: {3'd0, pixel_word[31:27]}, alp: alp_second,
                       maxv: MAX_5, force_full: 1'b0};
      end
      default: begin
        lane_in[0].chan = pixel_word[7:0];
        lane_in[1].chan = pixel_word[15:8];
        lane_in[2].chan = pixel_word[23:16];
      end
    endcase
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    mlp_lane u_lane (
      .clk      (clk),
      .lane_in  (lane_in[g]),
      .lane_out (lane_res[g])
    );
  end

  // Hold the raw word and format beside the lane results for the merge.
  always_ff @(posedge clk) begin
    s1_ctl.fmt       <= pixel_format;
    s1_ctl.mask_zero <= (mask_first == 8'd0);
    s1_ctl.word      <= pixel_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= accept;
      done     <= s1_valid;
    end
  end

  mlp_merge u_merge (
    .clk      (clk),
    .ctl      (s1_ctl),
    .lanes    (lane_res),
    .lit_word (lit_word)
  );

  `MLP_ASSERT_NEXT(a_done_follows, clk, rst, s1_valid, done, "done did not follow lane stage")
  `MLP_ASSERT_NOW(a_done_source, clk, rst, done, $past(s1_valid), "done without a transaction")
  `MLP_ASSERT_NEXT(a_555_high_zero, clk, rst, s1_valid && (s1_ctl.fmt == FMT_555),
                   lit_word[31:16] == 16'd0, "555 result has high bits set")
  `MLP_ASSERT_NEXT(a_32_skip_pass, clk, rst,
                   s1_valid && s1_ctl.mask_zero && (s1_ctl.fmt == FMT_32),
                   lit_word == $past(s1_ctl.word), "zero mask did not pass word through")

endmodule
